@@ src/vva_pkg.sv @@
// ----------------------------------------------------------------------------
// vva_pkg: shared codes and helpers for the vector alu
// operation codes, port width and the saturating narrowing function
// ----------------------------------------------------------------------------
package vva_pkg;

   localparam int OP_W   = 4;
   localparam int PORT_W = 32;
   localparam int MAG_W  = 66;

   localparam logic [OP_W-1:0] OP_ADD       = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB       = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL       = 4'd2;
   localparam logic [OP_W-1:0] OP_SCALE     = 4'd3;
   localparam logic [OP_W-1:0] OP_DIVIDE    = 4'd4;
   localparam logic [OP_W-1:0] OP_NEGATE    = 4'd5;
   localparam logic [OP_W-1:0] OP_DOT       = 4'd6;
   localparam logic [OP_W-1:0] OP_NORM      = 4'd7;
   localparam logic [OP_W-1:0] OP_NORMALIZE = 4'd8;

   // sign and magnitude to a val_bits value, sign-extended to 32 bits
   // bit 32 of the result is the saturation flag
   function automatic logic [PORT_W:0] sat_mag(input logic neg,
                                                input logic [MAG_W-1:0] mag,
                                                input int val_bits);
      logic [MAG_W-1:0]  lim;
      logic [PORT_W-1:0] min_v;
      lim   = (MAG_W'(1) << (val_bits - 1)) - MAG_W'(1);
      min_v = 32'hFFFF_FFFF << (val_bits - 1);
      if (neg) begin
         lim = lim + MAG_W'(1);
      end
      if (mag > lim) begin
         return {1'b1, (neg ? min_v : ~min_v)};
      end
      return {1'b0, (neg ? (~mag[PORT_W-1:0] + 32'd1) : mag[PORT_W-1:0])};
   endfunction

endpackage

@@ src/vva_front.sv @@
// ----------------------------------------------------------------------------
// vva_front: multiply, add and reduce stages
// three register stages: products and sums, lane saturation and dot sum,
// dot narrowing and radicand for the norm
// ----------------------------------------------------------------------------
module vva_front #(
   parameter int VAL_W  = 32,
   parameter int FRAC_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [vva_pkg::OP_W-1:0]      in_op,
   input  logic [3:0][VAL_W-1:0]         in_a,
   input  logic [3:0][VAL_W-1:0]         in_b,
   input  logic [VAL_W-1:0]              in_s,
   output logic                          out_valid,
   output logic [vva_pkg::OP_W-1:0]      out_op,
   output logic [3:0][VAL_W-1:0]         out_a,
   output logic [VAL_W-1:0]              out_s,
   output logic [3:0][VAL_W-1:0]         out_lane,
   output logic [3:0]                    out_lane_ovf,
   output logic [VAL_W-1:0]              out_sc,
   output logic                          out_sc_ovf,
   output logic [2*VAL_W+1:0]            out_rad
);

   localparam int PW = 2 * VAL_W;
   localparam int MW = 2 * VAL_W + 2;
   localparam int AW = VAL_W + 1;

   // stage 1
   logic                     v1_ff, v1_in;
   logic [vva_pkg::OP_W-1:0] op1_ff;
   logic [3:0][VAL_W-1:0]    a1_ff;
   logic [VAL_W-1:0]         s1_ff;
   logic [3:0][PW-1:0]       prod1_ff, prod1_in;
   logic [3:0][AW-1:0]       asum1_ff, asum1_in;

   // stage 2
   logic                     v2_ff;
   logic [vva_pkg::OP_W-1:0] op2_ff;
   logic [3:0][VAL_W-1:0]    a2_ff;
   logic [VAL_W-1:0]         s2_ff;
   logic [3:0][VAL_W-1:0]    lane2_ff, lane2_in;
   logic [3:0]               lovf2_ff, lovf2_in;
   logic [MW-1:0]            sum2_ff, sum2_in;

   // stage 3
   logic                     v3_ff;
   logic [vva_pkg::OP_W-1:0] op3_ff;
   logic [3:0][VAL_W-1:0]    a3_ff;
   logic [VAL_W-1:0]         s3_ff;
   logic [3:0][VAL_W-1:0]    lane3_ff;
   logic [3:0]               lovf3_ff;
   logic [VAL_W-1:0]         sc3_ff, sc3_in;
   logic                     scovf3_ff, scovf3_in;
   logic [MW-1:0]            rad3_ff;

   assign v1_in = in_valid;

   always_comb begin
      logic signed [VAL_W-1:0] opa, opb;
      logic signed [PW-1:0]    pa, pb;
      logic signed [AW-1:0]    ea, eb;
      for (int i = 0; i < 4; i++) begin
         opa = signed'(in_a[i]);
         if (in_op == vva_pkg::OP_SCALE) begin
            opb = signed'(in_s);
         end else if (in_op == vva_pkg::OP_NORM || in_op == vva_pkg::OP_NORMALIZE) begin
            opb = signed'(in_a[i]);
         end else begin
            opb = signed'(in_b[i]);
         end
         pa = PW'(opa);
         pb = PW'(opb);
         prod1_in[i] = pa * pb;
         ea = AW'(opa);
         eb = AW'(signed'(in_b[i]));
         unique case (in_op)
            vva_pkg::OP_SUB:    asum1_in[i] = ea - eb;
            vva_pkg::OP_NEGATE: asum1_in[i] = AW'(0) - ea;
            default:            asum1_in[i] = ea + eb;
         endcase
      end
   end

   always_comb begin
      logic [MW-1:0]             ext, mag;
      logic                      neg;
      logic [vva_pkg::PORT_W:0]  r;
      sum2_in = '0;
      for (int i = 0; i < 4; i++) begin
         if (op1_ff == vva_pkg::OP_ADD || op1_ff == vva_pkg::OP_SUB ||
             op1_ff == vva_pkg::OP_NEGATE) begin
            ext = MW'(signed'(asum1_ff[i]));
            neg = ext[MW-1];
            mag = neg ? (~ext + MW'(1)) : ext;
         end else begin
            ext = MW'(signed'(prod1_ff[i]));
            neg = ext[MW-1];
            mag = (neg ? (~ext + MW'(1)) : ext) >> FRAC_W;
         end
         r = vva_pkg::sat_mag(neg, vva_pkg::MAG_W'(mag), VAL_W);
         lane2_in[i] = r[VAL_W-1:0];
         lovf2_in[i] = r[vva_pkg::PORT_W];
         sum2_in = sum2_in + MW'(signed'(prod1_ff[i]));
      end
   end

   always_comb begin
      logic [MW-1:0]            mag;
      logic                     neg;
      logic [vva_pkg::PORT_W:0] r;
      neg = sum2_ff[MW-1];
      mag = (neg ? (~sum2_ff + MW'(1)) : sum2_ff) >> FRAC_W;
      r = vva_pkg::sat_mag(neg, vva_pkg::MAG_W'(mag), VAL_W);
      sc3_in    = r[VAL_W-1:0];
      scovf3_in = r[vva_pkg::PORT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff    <= in_op;
      a1_ff     <= in_a;
      s1_ff     <= in_s;
      prod1_ff  <= prod1_in;
      asum1_ff  <= asum1_in;
      op2_ff    <= op1_ff;
      a2_ff     <= a1_ff;
      s2_ff     <= s1_ff;
      lane2_ff  <= lane2_in;
      lovf2_ff  <= lovf2_in;
      sum2_ff   <= sum2_in;
      op3_ff    <= op2_ff;
      a3_ff     <= a2_ff;
      s3_ff     <= s2_ff;
      lane3_ff  <= lane2_ff;
      lovf3_ff  <= lovf2_ff;
      sc3_ff    <= sc3_in;
      scovf3_ff <= scovf3_in;
      rad3_ff   <= sum2_ff;
   end

   assign out_valid    = v3_ff;
   assign out_op       = op3_ff;
   assign out_a        = a3_ff;
   assign out_s        = s3_ff;
   assign out_lane     = lane3_ff;
   assign out_lane_ovf = lovf3_ff;
   assign out_sc       = sc3_ff;
   assign out_sc_ovf   = scovf3_ff;
   assign out_rad      = rad3_ff;

endmodule

@@ src/vva_sqrt.sv @@
// ----------------------------------------------------------------------------
// vva_sqrt: pipelined integer square root
// one root bit per stage, floor result, sideband travels alongside
// ----------------------------------------------------------------------------
module vva_sqrt #(
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int N = ROOT_W;

   logic [N-1:0]        vld_ff, vld_in;
   logic [2*N-1:0]      rad_ff  [N];
   logic [2*N-1:0]      rad_in  [N];
   logic [N+1:0]        rem_ff  [N];
   logic [N+1:0]        rem_in  [N];
   logic [N-1:0]        root_ff [N];
   logic [N-1:0]        root_in [N];
   logic [SIDE_W-1:0]   side_ff [N];
   logic [SIDE_W-1:0]   side_in [N];

   always_comb begin
      logic [2*N-1:0]    src_rad;
      logic [N+1:0]      src_rem, remx, trial;
      logic [N-1:0]      src_root;
      logic              ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            vld_in[k]  = in_valid;
            src_rad    = in_rad;
            src_rem    = '0;
            src_root   = '0;
            side_in[k] = in_side;
         end else begin
            vld_in[k]  = vld_ff[k-1];
            src_rad    = rad_ff[k-1];
            src_rem    = rem_ff[k-1];
            src_root   = root_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         remx  = {src_rem[N-1:0], src_rad[2*N-1 -: 2]};
         trial = {src_root, 2'b01};
         ge    = (remx >= trial);
         rem_in[k]  = ge ? (remx - trial) : remx;
         root_in[k] = {src_root[N-2:0], ge};
         rad_in[k]  = src_rad << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

@@ src/vva_div.sv @@
// ----------------------------------------------------------------------------
// vva_div: pipelined four-lane restoring divider
// one quotient bit per stage, divisor shared by all lanes
// ----------------------------------------------------------------------------
module vva_div #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 33,
   parameter int SIDE_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [3:0][NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic [3:0][NUM_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int N = NUM_W;

   logic [N-1:0]              vld_ff, vld_in;
   // dividend bits shift out at the top while quotient bits shift in below
   logic [3:0][NUM_W-1:0]     nq_ff   [N];
   logic [3:0][NUM_W-1:0]     nq_in   [N];
   logic [3:0][DEN_W-1:0]     rem_ff  [N];
   logic [3:0][DEN_W-1:0]     rem_in  [N];
   logic [DEN_W-1:0]          den_ff  [N];
   logic [DEN_W-1:0]          den_in  [N];
   logic [SIDE_W-1:0]         side_ff [N];
   logic [SIDE_W-1:0]         side_in [N];

   always_comb begin
      logic [3:0][NUM_W-1:0] src_nq;
      logic [3:0][DEN_W-1:0] src_rem;
      logic [DEN_W:0]        remx, diff;
      logic                  ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            vld_in[k]  = in_valid;
            src_nq     = in_num;
            src_rem    = '0;
            den_in[k]  = in_den;
            side_in[k] = in_side;
         end else begin
            vld_in[k]  = vld_ff[k-1];
            src_nq     = nq_ff[k-1];
            src_rem    = rem_ff[k-1];
            den_in[k]  = den_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         for (int i = 0; i < 4; i++) begin
            remx = {src_rem[i], src_nq[i][NUM_W-1]};
            diff = remx - {1'b0, den_in[k]};
            ge   = (remx >= {1'b0, den_in[k]});
            rem_in[k][i] = ge ? diff[DEN_W-1:0] : remx[DEN_W-1:0];
            nq_in[k][i]  = {src_nq[i][NUM_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         nq_ff[k]   <= nq_in[k];
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = nq_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

@@ src/vec4_vector_alu.sv @@
// ----------------------------------------------------------------------------
// vec4_vector_alu: four-component fixed-point vector alu
// add, sub, product, scale, divide, negate, dot, norm and normalize
// ----------------------------------------------------------------------------
// stages from start to rsp_valid: 3 front, VAL+1 root, 1 set-up, VAL+FRAC divider,
//   1 out
// throughput: one transfer per cycle; busy stays low, every item takes the
//   same path so results leave in order
// reset: synchronous, clears the valid bits of every stage and rsp_valid
// results cannot be stalled: rsp_valid marks a single-cycle transfer
module vec4_vector_alu #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_operation,
   input  logic [31:0] req_a_x,
   input  logic [31:0] req_a_y,
   input  logic [31:0] req_a_z,
   input  logic [31:0] req_a_w,
   input  logic [31:0] req_b_x,
   input  logic [31:0] req_b_y,
   input  logic [31:0] req_b_z,
   input  logic [31:0] req_b_w,
   input  logic [31:0] req_scalar_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_res_x,
   output logic [31:0] rsp_res_y,
   output logic [31:0] rsp_res_z,
   output logic [31:0] rsp_res_w,
   output logic [31:0] rsp_res_scalar,
   output logic        rsp_overflow_flag,
   output logic        rsp_div_zero_flag
);

   // value width: the word, capped at the 32-bit ports
   localparam int VAL_W  = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int ROOT_W = VAL_W + 1;
   localparam int NUM_W  = VAL_W + FRAC_BITS;
   localparam int DEN_W  = VAL_W + 1;
   localparam int OPW    = vva_pkg::OP_W;
   // sideband through the root stages
   localparam int SQ_SIDE_W  = OPW + 4*VAL_W + VAL_W + 4*VAL_W + 4 + VAL_W + 1;
   // sideband through the divider
   localparam int DV_SIDE_W  = OPW + 4*VAL_W + 4 + VAL_W + 1 + ROOT_W + 4 + 1;

   // never stalls the requester
   assign busy = 1'b0;

   // ---------------------------------------------------------------- front
   logic [3:0][VAL_W-1:0] req_a, req_b;

   assign req_a = {req_a_w[VAL_W-1:0], req_a_z[VAL_W-1:0],
                   req_a_y[VAL_W-1:0], req_a_x[VAL_W-1:0]};
   assign req_b = {req_b_w[VAL_W-1:0], req_b_z[VAL_W-1:0],
                   req_b_y[VAL_W-1:0], req_b_x[VAL_W-1:0]};

   logic                  fr_valid;
   logic [OPW-1:0]        fr_op;
   logic [3:0][VAL_W-1:0] fr_a;
   logic [VAL_W-1:0]      fr_s;
   logic [3:0][VAL_W-1:0] fr_lane;
   logic [3:0]            fr_lane_ovf;
   logic [VAL_W-1:0]      fr_sc;
   logic                  fr_sc_ovf;
   logic [2*ROOT_W-1:0]   fr_rad;

   vva_front #(
      .VAL_W  (VAL_W),
      .FRAC_W (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start & ~busy),
      .in_op        (req_operation),
      .in_a         (req_a),
      .in_b         (req_b),
      .in_s         (req_scalar_in[VAL_W-1:0]),
      .out_valid    (fr_valid),
      .out_op       (fr_op),
      .out_a        (fr_a),
      .out_s        (fr_s),
      .out_lane     (fr_lane),
      .out_lane_ovf (fr_lane_ovf),
      .out_sc       (fr_sc),
      .out_sc_ovf   (fr_sc_ovf),
      .out_rad      (fr_rad)
   );

   // ---------------------------------------------------------------- root
   logic                  sq_valid;
   logic [ROOT_W-1:0]     sq_root;
   logic [SQ_SIDE_W-1:0]  sq_side;
   logic [OPW-1:0]        sq_op;
   logic [3:0][VAL_W-1:0] sq_a;
   logic [VAL_W-1:0]      sq_s;
   logic [3:0][VAL_W-1:0] sq_lane;
   logic [3:0]            sq_lane_ovf;
   logic [VAL_W-1:0]      sq_sc;
   logic                  sq_sc_ovf;

   vva_sqrt #(
      .ROOT_W (ROOT_W),
      .SIDE_W (SQ_SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   ({fr_op, fr_a, fr_s, fr_lane, fr_lane_ovf, fr_sc, fr_sc_ovf}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_op, sq_a, sq_s, sq_lane, sq_lane_ovf, sq_sc, sq_sc_ovf} = sq_side;

   // ------------------------------------------------------ divider set-up
   // divisor is the scalar for divide and the norm for normalize
   logic                  su_valid_ff;
   logic [3:0][NUM_W-1:0] su_num_ff, su_num_in;
   logic [DEN_W-1:0]      su_den_ff, su_den_in;
   logic [DV_SIDE_W-1:0]  su_side_ff, su_side_in;

   always_comb begin
      logic [VAL_W-1:0] s_mag, a_mag;
      logic [3:0]       neg;
      logic             dz, is_div;
      is_div = (sq_op == vva_pkg::OP_DIVIDE);
      s_mag  = sq_s[VAL_W-1] ? (~sq_s + VAL_W'(1)) : sq_s;
      for (int i = 0; i < 4; i++) begin
         a_mag = sq_a[i][VAL_W-1] ? (~sq_a[i] + VAL_W'(1)) : sq_a[i];
         su_num_in[i] = {a_mag, {FRAC_BITS{1'b0}}};
         neg[i] = sq_a[i][VAL_W-1] ^ (is_div & sq_s[VAL_W-1]);
      end
      su_den_in = is_div ? {1'b0, s_mag} : sq_root;
      dz = (is_div && sq_s == '0) ||
           (sq_op == vva_pkg::OP_NORMALIZE && sq_root == '0);
      su_side_in = {sq_op, sq_lane, sq_lane_ovf, sq_sc, sq_sc_ovf, sq_root, neg, dz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_valid_ff <= 1'b0;
      end else begin
         su_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      su_num_ff  <= su_num_in;
      su_den_ff  <= su_den_in;
      su_side_ff <= su_side_in;
   end

   // ------------------------------------------------------------- divider
   logic                  dv_valid;
   logic [3:0][NUM_W-1:0] dv_quo;
   logic [DV_SIDE_W-1:0]  dv_side;
   logic [OPW-1:0]        dv_op;
   logic [3:0][VAL_W-1:0] dv_lane;
   logic [3:0]            dv_lane_ovf;
   logic [VAL_W-1:0]      dv_sc;
   logic                  dv_sc_ovf;
   logic [ROOT_W-1:0]     dv_root;
   logic [3:0]            dv_neg;
   logic                  dv_dz;

   vva_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .SIDE_W (DV_SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (su_valid_ff),
      .in_num    (su_num_ff),
      .in_den    (su_den_ff),
      .in_side   (su_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   assign {dv_op, dv_lane, dv_lane_ovf, dv_sc, dv_sc_ovf, dv_root, dv_neg, dv_dz} = dv_side;

   // ---------------------------------------------------------- result mux
   logic                  out_valid_ff;
   logic [3:0][VAL_W-1:0] res_ff, res_in;
   logic [VAL_W-1:0]      sc_ff, sc_in;
   logic                  ovf_ff, ovf_in;
   logic                  dz_ff, dz_in;

   always_comb begin
      logic [vva_pkg::PORT_W:0] r, nr;
      logic [3:0][VAL_W-1:0]    qv;
      logic [3:0]               qovf;
      for (int i = 0; i < 4; i++) begin
         r = vva_pkg::sat_mag(dv_neg[i], vva_pkg::MAG_W'(dv_quo[i]), VAL_W);
         qv[i]   = r[VAL_W-1:0];
         qovf[i] = r[vva_pkg::PORT_W];
      end
      nr = vva_pkg::sat_mag(1'b0, vva_pkg::MAG_W'(dv_root), VAL_W);
      res_in = '0;
      sc_in  = '0;
      ovf_in = 1'b0;
      dz_in  = 1'b0;
      unique case (dv_op)
         vva_pkg::OP_ADD, vva_pkg::OP_SUB, vva_pkg::OP_MUL,
         vva_pkg::OP_SCALE, vva_pkg::OP_NEGATE: begin
            res_in = dv_lane;
            ovf_in = |dv_lane_ovf;
         end
         vva_pkg::OP_DIVIDE, vva_pkg::OP_NORMALIZE: begin
            // zero divisor or zero vector: zeros with the flag
            dz_in = dv_dz;
            if (!dv_dz) begin
               res_in = qv;
               ovf_in = |qovf;
            end
         end
         vva_pkg::OP_DOT: begin
            sc_in  = dv_sc;
            ovf_in = dv_sc_ovf;
         end
         vva_pkg::OP_NORM: begin
            sc_in  = nr[VAL_W-1:0];
            ovf_in = nr[vva_pkg::PORT_W];
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      sc_ff  <= sc_in;
      ovf_ff <= ovf_in;
      dz_ff  <= dz_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_res_x         = 32'(signed'(res_ff[0]));
   assign rsp_res_y         = 32'(signed'(res_ff[1]));
   assign rsp_res_z         = 32'(signed'(res_ff[2]));
   assign rsp_res_w         = 32'(signed'(res_ff[3]));
   assign rsp_res_scalar    = 32'(signed'(sc_ff));
   assign rsp_overflow_flag = ovf_ff;
   assign rsp_div_zero_flag = dz_ff;

endmodule

@@ src/vva_checker.sv @@
// ----------------------------------------------------------------------------
// vva_checker: port-level checks for the vector alu
// reset clearing and consistency of the result flags
// ----------------------------------------------------------------------------
module vva_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic [31:0] rsp_res_x,
   input logic [31:0] rsp_res_y,
   input logic [31:0] rsp_res_z,
   input logic [31:0] rsp_res_w,
   input logic [31:0] rsp_res_scalar,
   input logic        rsp_overflow_flag,
   input logic        rsp_div_zero_flag
);

   // no transfer straight after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // a zero divisor never also saturates
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow_flag && rsp_div_zero_flag))
      else $error("both flags raised");

   // zero divisor gives an all-zero result
   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero_flag) |->
         (rsp_res_x == 32'd0 && rsp_res_y == 32'd0 && rsp_res_z == 32'd0 &&
          rsp_res_w == 32'd0 && rsp_res_scalar == 32'd0))
      else $error("non-zero result with divide by zero");

endmodule

bind vec4_vector_alu vva_checker u_vva_checker (.*);
